### hw/rtl/rct_pkg.sv
// ----------------------------------------------------------------------------
// rct_pkg
// Shared types, constants and helpers for the RANSAC consensus tracker.
// ----------------------------------------------------------------------------
package rct_pkg;

   localparam int MAX_POINTS      = 1024;
   localparam int MAX_SAMPLE_SIZE = 8;

   // point index / count width, mask word count and word address width
   localparam int NW         = $clog2(MAX_POINTS + 1);
   localparam int MASK_WORDS = (MAX_POINTS + 31) / 32;
   localparam int WA_W       = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;
   localparam int SW         = $clog2(MAX_SAMPLE_SIZE + 1);

   // csr reset values
   localparam logic [31:0] DIST_THR_RST   = 32'd65536;
   localparam logic [10:0] POINT_CNT_RST  = 11'd1024;
   localparam logic [3:0]  SAMPLE_RST     = 4'd4;
   localparam logic [15:0] TRIAL_CAP_RST  = 16'd1000;
   localparam logic [31:0] MISS_PROB_RST  = 32'd42949673;

   typedef enum logic [2:0] {
      CSR_DIST_THR    = 3'd0,
      CSR_POINT_COUNT = 3'd1,
      CSR_SAMPLE_SIZE = 3'd2,
      CSR_TRIAL_CAP   = 3'd3,
      CSR_MISS_PROB   = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_DIV, ST_POW, ST_SRCH, ST_FIN, ST_SUM, ST_RD, ST_WORD
   } back_state_type;

   typedef struct packed {
      logic [31:0] distance_threshold;
      logic [10:0] point_count;
      logic [3:0]  sample_size;
      logic [15:0] trial_cap;
      logic [31:0] miss_probability;
   } cfg_type;

   typedef struct packed {
      logic [31:0] distance;
      logic        last_point;
      logic        new_estimation;
   } req_type;

   typedef struct packed {
      logic        item_kind;
      logic [10:0] inlier_count;
      logic [10:0] best_count;
      logic [15:0] trials_done;
      logic [15:0] trial_limit;
      logic        stop;
      logic [31:0] mask_word;
      logic        last_of_run;
   } rsp_type;

   // trial close command, front to back
   typedef struct packed {
      logic [NW-1:0] trial_count;
      logic [NW-1:0] best_total;
   } cmd_type;

   // front to back control
   typedef struct packed {
      logic fresh;
   } ctl_type;

   function automatic logic [NW-1:0] eff_points(input logic [10:0] pc);
      logic [NW-1:0] n;
      if (pc == 11'd0) n = NW'(1);
      else if (32'(pc) > MAX_POINTS) n = NW'(MAX_POINTS);
      else n = NW'(pc);
      return n;
   endfunction

   function automatic logic [SW-1:0] eff_sample(input logic [3:0] s);
      logic [SW-1:0] r;
      if (s == 4'd0) r = SW'(1);
      else if (32'(s) > MAX_SAMPLE_SIZE) r = SW'(MAX_SAMPLE_SIZE);
      else r = SW'(s);
      return r;
   endfunction

endpackage

### hw/rtl/ransac_consensus_tracker_top.sv
// ----------------------------------------------------------------------------
// ransac_consensus_tracker_top
// RANSAC consensus tracker with adaptive trial limit and best-mask readout.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake              | beat
//  ---------+-----------+------------------------+------------------------------
//  req_     | in        | push / full            | one point distance + flags
//  rsp_     | out       | pop / empty            | summary or one best-mask word
//  csr_     | in        | valid / ready (always) | register index + write data
//
//  Points that do not close a trial stream back to back. A closing point raises
//  full from the next cycle until the back end is idle again: it takes the
//  command, runs the inlier ratio divider, forms w^s (s-1 multiplies), runs the
//  trial search up to the limit, updates the trial count, sends the summary and
//  reads and sends each mask word; any result may also wait for pop. All
//  points inliers or a zero limit skip straight to the trial
//  count; w^s of zero skips the search. One shared 32x32 multiplier. The result
//  register lets the front accept the next trial while the last result waits.
//  Reset is synchronous; csr registers return to their defaults, no clearing
//  pass is needed (mask words carry valid bits).
//
module ransac_consensus_tracker_top import rct_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // point input
   input  logic        req_push,
   input  req_type     req_data,
   output logic        req_full,
   // results
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output rsp_type     rsp_data,
   // configuration
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   cfg_type         cfg_ff, cfg_in;
   cmd_type         push_cmd, pop_cmd;
   logic            cmd_push, cmd_pop, q_empty;
   logic            back_busy, back_pending;
   ctl_type         ctl;
   logic [WA_W-1:0] rd_addr;
   logic [31:0]     rd_word;

   // csr write port never stalls
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_DIST_THR:    cfg_in.distance_threshold = csr_wdata;
            CSR_POINT_COUNT: cfg_in.point_count        = csr_wdata[10:0];
            CSR_SAMPLE_SIZE: cfg_in.sample_size        = csr_wdata[3:0];
            CSR_TRIAL_CAP:   cfg_in.trial_cap          = csr_wdata[15:0];
            CSR_MISS_PROB:   cfg_in.miss_probability   = csr_wdata;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.distance_threshold <= DIST_THR_RST;
         cfg_ff.point_count        <= POINT_CNT_RST;
         cfg_ff.sample_size        <= SAMPLE_RST;
         cfg_ff.trial_cap          <= TRIAL_CAP_RST;
         cfg_ff.miss_probability   <= MISS_PROB_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front holds off while a trial close is queued or in progress
   assign back_pending = !q_empty || back_busy;

   rct_front u_front (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .req_push     (req_push),
      .req_data     (req_data),
      .req_full     (req_full),
      .back_pending (back_pending),
      .cmd_push     (cmd_push),
      .cmd_data     (push_cmd),
      .ctl          (ctl),
      .rd_addr      (rd_addr),
      .rd_word      (rd_word)
   );

   rct_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (push_cmd),
      .pop       (cmd_pop),
      .pop_data  (pop_cmd),
      .empty     (q_empty)
   );

   rct_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .ctl       (ctl),
      .cmd_valid (!q_empty),
      .cmd_data  (pop_cmd),
      .cmd_pop   (cmd_pop),
      .busy      (back_busy),
      .rd_addr   (rd_addr),
      .rd_word   (rd_word),
      .rsp_pop   (rsp_pop),
      .rsp_empty (rsp_empty),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/rct_cmd_queue.sv
// ----------------------------------------------------------------------------
// rct_cmd_queue
// Two-entry queue of trial close commands between front and back.
// ----------------------------------------------------------------------------
module rct_cmd_queue import rct_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   input  logic    pop,
   output cmd_type pop_data,
   output logic    empty
);

   cmd_type    ent_ff [2];
   logic       wp_ff, wp_in;
   logic       rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && (cnt_ff != 2'd2);
   assign do_pop  = pop && !empty;
   assign pop_data = ent_ff[rp_ff];

   always_comb begin
      wp_in  = wp_ff ^ do_push;
      rp_in  = rp_ff ^ do_pop;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) ent_ff[wp_ff] <= push_data;
   end

endmodule

### hw/rtl/rct_front.sv
// ----------------------------------------------------------------------------
// rct_front
// Classifies distances, builds the trial mask, tracks best count and banks.
// ----------------------------------------------------------------------------
module rct_front import rct_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            req_push,
   input  req_type         req_data,
   output logic            req_full,
   input  logic            back_pending,
   output logic            cmd_push,
   output cmd_type         cmd_data,
   output ctl_type         ctl,
   input  logic [WA_W-1:0] rd_addr,
   output logic [31:0]     rd_word
);

   localparam int DEPTH = 2 ** (WA_W + 1);

   // two mask banks; bank_ff holds the trial in progress, the other the best
   logic [31:0]                 mem [DEPTH];
   logic [1:0][MASK_WORDS-1:0]  vld_ff, vld_in;
   logic                        bank_ff, bank_in;
   logic [NW-1:0]               idx_ff, idx_in;
   logic [NW-1:0]               tot_ff, tot_in;
   logic [NW-1:0]               best_ff, best_in;
   logic [31:0]                 acc_ff, acc_in;
   logic [31:0]                 rd_data_ff;
   logic                        rd_vld_ff;

   logic          accept, fresh, take, inl, better;
   logic [NW-1:0] n, idx_base, tot_base, best_base, tot_next;
   logic [4:0]    bitpos;
   logic [WA_W-1:0] waddr;

   assign req_full    = back_pending;
   assign accept      = req_push && !req_full;
   assign fresh       = accept && req_data.new_estimation;
   assign ctl.fresh   = fresh;

   always_comb begin
      n         = eff_points(cfg.point_count);
      idx_base  = req_data.new_estimation ? '0 : idx_ff;
      tot_base  = req_data.new_estimation ? '0 : tot_ff;
      best_base = req_data.new_estimation ? '0 : best_ff;
      take      = idx_base < n;
      inl       = take && (req_data.distance < cfg.distance_threshold);
      bitpos    = idx_base[4:0];
      waddr     = WA_W'(idx_base >> 5);
      acc_in    = ((bitpos == 5'd0) ? 32'd0 : acc_ff) | (32'(inl) << bitpos);
      tot_next  = tot_base + NW'(inl);
      better    = tot_next > best_base;

      idx_in  = idx_ff;
      tot_in  = tot_ff;
      best_in = best_ff;
      bank_in = bank_ff;
      vld_in  = vld_ff;
      if (accept) begin
         if (req_data.new_estimation) vld_in = '0;
         if (take) vld_in[bank_ff][waddr] = 1'b1;
         idx_in  = idx_base + NW'(take);
         tot_in  = tot_next;
         best_in = best_base;
         if (req_data.last_point) begin
            idx_in = '0;
            tot_in = '0;
            if (better) begin
               best_in = tot_next;
               bank_in = !bank_ff;
            end
            vld_in[bank_in] = '0;
         end
      end

      cmd_push             = accept && req_data.last_point;
      cmd_data.trial_count = tot_next;
      cmd_data.best_total  = better ? tot_next : best_base;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff  <= '0;
         tot_ff  <= '0;
         best_ff <= '0;
         bank_ff <= 1'b0;
         vld_ff  <= '0;
      end else begin
         idx_ff  <= idx_in;
         tot_ff  <= tot_in;
         best_ff <= best_in;
         bank_ff <= bank_in;
         vld_ff  <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) acc_ff <= acc_in;
      if (accept && take) mem[{bank_ff, waddr}] <= acc_in;
      rd_data_ff <= mem[{!bank_ff, rd_addr}];
      rd_vld_ff  <= vld_ff[!bank_ff][rd_addr];
   end

   assign rd_word = rd_vld_ff ? rd_data_ff : 32'd0;

endmodule

### hw/rtl/rct_back.sv
// ----------------------------------------------------------------------------
// rct_back
// Trial close: adaptive limit search, trial count, summary and mask stream.
// ----------------------------------------------------------------------------
module rct_back import rct_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  ctl_type         ctl,
   input  logic            cmd_valid,
   input  cmd_type         cmd_data,
   output logic            cmd_pop,
   output logic            busy,
   output logic [WA_W-1:0] rd_addr,
   input  logic [31:0]     rd_word,
   input  logic            rsp_pop,
   output logic            rsp_empty,
   output rsp_type         rsp_data
);

   back_state_type  state_ff, state_in;
   logic [15:0]     tc_ff, tc_in;
   logic [15:0]     lim_ff, lim_in;
   logic [NW-1:0]   trial_ff, trial_in;
   logic [NW-1:0]   best_ff, best_in;
   logic [NW-1:0]   rem_ff, rem_in;
   logic [31:0]     w_ff, w_in;
   logic [31:0]     p_ff, p_in;
   logic [15:0]     cnt_ff, cnt_in;
   logic [WA_W-1:0] wi_ff, wi_in;
   rsp_type         out_ff, out_in;
   logic            out_vld_ff, out_vld_in;

   logic [NW-1:0]   n;
   logic [SW-1:0]   s;
   logic [63:0]     prod;
   logic [31:0]     hi;
   logic [NW:0]     rem2;
   logic            slot_free, stop_now;
   logic [WA_W-1:0] last_wi;
   logic [31:0]     mword;

   assign busy      = (state_ff != ST_IDLE);
   assign rd_addr   = wi_ff;
   assign rsp_empty = !out_vld_ff;
   assign rsp_data  = out_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      n         = eff_points(cfg.point_count);
      s         = eff_sample(cfg.sample_size);
      prod      = 64'(p_ff) * 64'(w_ff);
      hi        = prod[63:32];
      rem2      = {rem_ff, 1'b0};
      slot_free = !out_vld_ff || rsp_pop;
      stop_now  = tc_ff >= lim_ff;
      last_wi   = WA_W'((n - NW'(1)) >> 5);
      mword     = rd_word;
      if ((wi_ff == last_wi) && (n[4:0] != 5'd0))
         mword = rd_word & ((32'd1 << n[4:0]) - 32'd1);

      state_in   = state_ff;
      tc_in      = tc_ff;
      lim_in     = lim_ff;
      trial_in   = trial_ff;
      best_in    = best_ff;
      rem_in     = rem_ff;
      w_in       = w_ff;
      p_in       = p_ff;
      cnt_in     = cnt_ff;
      wi_in      = wi_ff;
      out_in     = out_ff;
      out_vld_in = out_vld_ff && !rsp_pop;
      cmd_pop    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (ctl.fresh) begin
               tc_in  = '0;
               lim_in = cfg.trial_cap;
            end else if (cmd_valid) begin
               cmd_pop  = 1'b1;
               trial_in = cmd_data.trial_count;
               best_in  = cmd_data.best_total;
               rem_in   = cmd_data.best_total;
               cnt_in   = '0;
               if (cmd_data.best_total >= n) begin
                  lim_in   = '0;
                  state_in = ST_FIN;
               end else if (lim_ff == 16'd0) begin
                  state_in = ST_FIN;
               end else begin
                  state_in = ST_DIV;
               end
            end
         end
         // w = best * 2^32 / n, one quotient bit a cycle
         ST_DIV: begin
            if (rem2 >= {1'b0, n}) begin
               rem_in = NW'(rem2 - {1'b0, n});
               w_in   = {w_ff[30:0], 1'b1};
            end else begin
               rem_in = NW'(rem2);
               w_in   = {w_ff[30:0], 1'b0};
            end
            cnt_in = cnt_ff + 16'd1;
            if (cnt_ff == 16'd31) begin
               p_in     = w_in;
               cnt_in   = 16'd1;
               state_in = ST_POW;
            end
         end
         // p = w^s, truncated each step
         ST_POW: begin
            if (cnt_ff < 16'(s)) begin
               p_in   = hi;
               cnt_in = cnt_ff + 16'd1;
            end else if (p_ff == 32'd0) begin
               state_in = ST_FIN;
            end else begin
               w_in     = 32'd0 - p_ff;
               p_in     = 32'd0 - p_ff;
               cnt_in   = 16'd1;
               state_in = ST_SRCH;
            end
         end
         // r = q^N until r <= miss probability or N reaches the limit
         ST_SRCH: begin
            if ((p_ff > cfg.miss_probability) && (cnt_ff < lim_ff)) begin
               p_in   = hi;
               cnt_in = cnt_ff + 16'd1;
            end else begin
               if (cnt_ff < lim_ff) lim_in = cnt_ff;
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (tc_ff != 16'hFFFF) tc_in = tc_ff + 16'd1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            if (slot_free) begin
               out_in.item_kind    = 1'b0;
               out_in.inlier_count = 11'(trial_ff);
               out_in.best_count   = 11'(best_ff);
               out_in.trials_done  = tc_ff;
               out_in.trial_limit  = lim_ff;
               out_in.stop         = stop_now;
               out_in.mask_word    = 32'd0;
               out_in.last_of_run  = !stop_now;
               out_vld_in          = 1'b1;
               wi_in               = '0;
               state_in            = stop_now ? ST_RD : ST_IDLE;
            end
         end
         ST_RD: begin
            state_in = ST_WORD;
         end
         ST_WORD: begin
            if (slot_free) begin
               out_in.item_kind   = 1'b1;
               out_in.mask_word   = mword;
               out_in.last_of_run = (wi_ff == last_wi);
               out_vld_in         = 1'b1;
               if (wi_ff == last_wi) begin
                  state_in = ST_IDLE;
               end else begin
                  wi_in    = wi_ff + WA_W'(1);
                  state_in = ST_RD;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff      <= '0;
         lim_ff     <= TRIAL_CAP_RST;
         out_vld_ff <= 1'b0;
         cnt_ff     <= '0;
         wi_ff      <= '0;
      end else begin
         tc_ff      <= tc_in;
         lim_ff     <= lim_in;
         out_vld_ff <= out_vld_in;
         cnt_ff     <= cnt_in;
         wi_ff      <= wi_in;
      end
   end

   always_ff @(posedge clock) begin
      trial_ff <= trial_in;
      best_ff  <= best_in;
      rem_ff   <= rem_in;
      w_ff     <= w_in;
      p_ff     <= p_in;
      out_ff   <= out_in;
   end

endmodule

### sim/tb_ransac_consensus_tracker_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ransac_consensus_tracker_top
// Drives point distances through the tracker and checks every summary and
// best-mask beat against a cycle-free model of consensus, limit and readout.
// ----------------------------------------------------------------------------
module tb_ransac_consensus_tracker_top import rct_pkg::*; ();

   localparam int WATCHDOG_LIMIT = 500000;

   logic        clock;
   logic        reset;
   logic        req_push;
   req_type     req_data;
   logic        req_full;
   logic        rsp_pop;
   logic        rsp_empty;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   ransac_consensus_tracker_top dut (.*);

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model copy of the configuration and run state
   logic [31:0] thr_q;
   logic [10:0] pts_q;
   logic [3:0]  smp_q;
   logic [15:0] cap_q;
   logic [31:0] miss_q;
   logic [MAX_POINTS-1:0] cur_bits;
   logic [MAX_POINTS-1:0] best_bits;
   int unsigned pidx, cur_cnt, best_cnt, trials, limit_q;

   rsp_type expected_beats[$];
   int      fail_count;
   int      idle_cycles;
   int      rsp_idle_pct;
   int      req_idle_pct;

   // smallest N with (1-w^s)^N <= miss, searched only below the current limit
   task automatic shrink_limit();
      int unsigned n, s, cnt;
      logic [63:0] w, p, q, r;
      n = (pts_q == 0) ? 1 : (pts_q > MAX_POINTS ? MAX_POINTS : pts_q);
      s = (smp_q == 0) ? 1 : (smp_q > MAX_SAMPLE_SIZE ? MAX_SAMPLE_SIZE : smp_q);
      if (best_cnt >= n) begin
         limit_q = 0;
         return;
      end
      if (limit_q == 0) return;
      w = (64'(best_cnt) << 32) / n;
      p = w;
      for (int k = 1; k < s; k++) p = (p * w) >> 32;
      if (p == 0) return;
      q = (64'd1 << 32) - p;
      r = q;
      cnt = 1;
      while (r > miss_q && cnt < limit_q) begin
         r = (r * q) >> 32;
         cnt++;
      end
      if (r <= miss_q && cnt < limit_q) limit_q = cnt;
   endtask

   task automatic predict_point(input req_type it);
      int unsigned n, words, lo;
      bit halt;
      rsp_type b;
      n = (pts_q == 0) ? 1 : (pts_q > MAX_POINTS ? MAX_POINTS : pts_q);
      if (it.new_estimation) begin
         cur_bits = '0; pidx = 0; cur_cnt = 0;
         best_bits = '0; best_cnt = 0; trials = 0; limit_q = cap_q;
      end
      if (pidx < n) begin
         if (it.distance < thr_q) begin
            cur_bits[pidx] = 1'b1;
            cur_cnt++;
         end
         pidx++;
      end
      if (!it.last_point) return;
      b.inlier_count = 11'(cur_cnt);
      if (cur_cnt > best_cnt) begin
         best_cnt = cur_cnt;
         best_bits = cur_bits;
      end
      shrink_limit();
      if (trials < 16'hFFFF) trials++;
      halt = (trials >= limit_q);
      words = halt ? (n + 31) / 32 : 0;
      b.best_count = 11'(best_cnt);
      b.trials_done = 16'(trials);
      b.trial_limit = 16'(limit_q);
      b.stop = halt;
      for (int k = 0; k <= words; k++) begin
         b.item_kind = (k > 0);
         b.mask_word = '0;
         if (k > 0) begin
            lo = (k - 1) * 32;
            b.mask_word = best_bits[lo +: 32];
            if (n - lo < 32) b.mask_word &= (32'd1 << (n - lo)) - 1;
         end
         b.last_of_run = (k == words);
         expected_beats.push_back(b);
      end
      cur_bits = '0; pidx = 0; cur_cnt = 0;
   endtask

   // one beat into the block; model updated on acceptance
   task automatic send_point(input logic [31:0] dist_val, input bit last, input bit fresh);
      req_type it;
      it.distance = dist_val;
      it.last_point = last;
      it.new_estimation = fresh;
      if ($urandom_range(99) < req_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < req_idle_pct) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (req_full) @(posedge clock);
      predict_point(it);
   endtask

   task automatic drain();
      req_push <= 1'b0;
      while (expected_beats.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [31:0] val);
      req_push  <= 1'b0;
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_DIST_THR:    thr_q = val;
         CSR_POINT_COUNT: pts_q = val[10:0];
         CSR_SAMPLE_SIZE: smp_q = val[3:0];
         CSR_TRIAL_CAP:   cap_q = val[15:0];
         CSR_MISS_PROB:   miss_q = val;
         default: ;
      endcase
   endtask

   // distance below or at/above the threshold so roughly pct percent are inliers
   function automatic logic [31:0] pick_dist(input int pct);
      if ($urandom_range(99) < pct) return (thr_q == 0) ? 32'd0 : $urandom_range(thr_q - 1, 0);
      if (thr_q == 32'hFFFF_FFFF) return 32'hFFFF_FFFF;
      return $urandom_range(32'hFFFF_FFFF, thr_q);
   endfunction

   task automatic send_trial(input int npts, input int pct, input bit fresh);
      for (int i = 0; i < npts; i++)
         send_point(pick_dist(pct), i == npts - 1, fresh && i == 0);
   endtask

   // extremes of distance and flags with a tiny trial size
   task automatic test_directed();
      write_reg(CSR_POINT_COUNT, 32'd4);
      write_reg(CSR_SAMPLE_SIZE, 32'd1);
      write_reg(CSR_TRIAL_CAP, 32'd5);
      write_reg(CSR_DIST_THR, 32'h0001_0000);
      write_reg(CSR_MISS_PROB, 32'd42949673);
      send_point(32'd0, 0, 1);
      send_point(32'hFFFF_FFFF, 0, 0);
      send_point(32'h0000_FFFF, 0, 0);
      send_point(32'h0001_0000, 1, 0);         // exactly at threshold: outlier
      send_point(32'd0, 1, 0);                 // single-point trial
      // extra points past the count are ignored
      for (int i = 0; i < 6; i++) send_point(32'd0, i == 5, 0);
      send_point(32'd5, 1, 1);                 // fresh on a closing point
      send_point(32'hFFFF_FFFF, 1, 0);
      drain();
      // zero threshold: nothing is an inlier; huge threshold: all but max
      write_reg(CSR_DIST_THR, 32'd0);
      send_trial(4, 50, 1);
      drain();
      write_reg(CSR_DIST_THR, 32'hFFFF_FFFF);
      send_trial(4, 100, 0);
      drain();
      // point count and sample size out of range clamp
      write_reg(CSR_POINT_COUNT, 32'd0);
      write_reg(CSR_SAMPLE_SIZE, 32'd0);
      send_trial(2, 50, 1);
      drain();
      write_reg(CSR_SAMPLE_SIZE, 32'd15);
      write_reg(CSR_MISS_PROB, 32'd1);
      write_reg(CSR_TRIAL_CAP, 32'd65535);
      write_reg(CSR_POINT_COUNT, 32'h7FF);
      send_trial(3, 50, 1);
      drain();
   endtask

   // best count at or above the lowered point count forces a zero limit
   task automatic test_shrink_count();
      write_reg(CSR_DIST_THR, 32'h0001_0000);
      write_reg(CSR_POINT_COUNT, 32'd40);
      write_reg(CSR_SAMPLE_SIZE, 32'd2);
      write_reg(CSR_TRIAL_CAP, 32'd30);
      write_reg(CSR_MISS_PROB, 32'd42949673);
      send_trial(40, 90, 1);
      drain();
      write_reg(CSR_POINT_COUNT, 32'd33);
      send_trial(33, 10, 0);
      drain();
   endtask

   task automatic test_random(input int budget);
      int sent, npts;
      sent = 0;
      while (sent < budget) begin
         case ($urandom_range(3))
            0: begin
               write_reg(CSR_POINT_COUNT, $urandom_range(40, 1));
               write_reg(CSR_SAMPLE_SIZE, $urandom_range(8, 1));
               write_reg(CSR_TRIAL_CAP, $urandom_range(20, 1));
               write_reg(CSR_MISS_PROB, $urandom);
               write_reg(CSR_DIST_THR, $urandom);
            end
            default: ;
         endcase
         npts = (pts_q == 0) ? 1 : pts_q;
         if ($urandom_range(9) == 0) npts = $urandom_range(npts + 3, 1);   // ragged trial
         send_trial(npts, $urandom_range(100), $urandom_range(5) == 0);
         sent += npts;
         if (sent > budget / 2 && sent - npts <= budget / 2) begin
            // quiet stretch with no idling on either side
            req_idle_pct = 0; rsp_idle_pct = 0;
         end
         drain();
         req_idle_pct = 20; rsp_idle_pct = 20;
      end
   endtask

   // result side: random pops, compare against oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_beats.size() == 0) begin
               $error("unexpected result beat %h", rsp_data);
               fail_count++;
            end else begin
               e = expected_beats.pop_front();
               if (rsp_data.item_kind !== e.item_kind) begin
                  $error("item_kind exp %0d got %0d", e.item_kind, rsp_data.item_kind);
                  fail_count++;
               end
               if (rsp_data.inlier_count !== e.inlier_count) begin
                  $error("inlier_count exp %0d got %0d", e.inlier_count, rsp_data.inlier_count);
                  fail_count++;
               end
               if (rsp_data.best_count !== e.best_count) begin
                  $error("best_count exp %0d got %0d", e.best_count, rsp_data.best_count);
                  fail_count++;
               end
               if (rsp_data.trials_done !== e.trials_done) begin
                  $error("trials_done exp %0d got %0d", e.trials_done, rsp_data.trials_done);
                  fail_count++;
               end
               if (rsp_data.trial_limit !== e.trial_limit) begin
                  $error("trial_limit exp %0d got %0d", e.trial_limit, rsp_data.trial_limit);
                  fail_count++;
               end
               if (rsp_data.stop !== e.stop) begin
                  $error("stop exp %0d got %0d", e.stop, rsp_data.stop);
                  fail_count++;
               end
               if (rsp_data.mask_word !== e.mask_word) begin
                  $error("mask_word exp %h got %h", e.mask_word, rsp_data.mask_word);
                  fail_count++;
               end
               if (rsp_data.last_of_run !== e.last_of_run) begin
                  $error("last_of_run exp %0d got %0d", e.last_of_run, rsp_data.last_of_run);
                  fail_count++;
               end
            end
         end
         rsp_pop <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // watchdog: cycles with no beat accepted on any channel
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      rsp_pop = 1'b0;
      fail_count = 0;
      idle_cycles = 0;
      req_idle_pct = 20;
      rsp_idle_pct = 20;
      thr_q = DIST_THR_RST; pts_q = POINT_CNT_RST; smp_q = SAMPLE_RST;
      cap_q = TRIAL_CAP_RST; miss_q = MISS_PROB_RST;
      cur_bits = '0; best_bits = '0; pidx = 0; cur_cnt = 0;
      best_cnt = 0; trials = 0; limit_q = TRIAL_CAP_RST;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_shrink_count();
      test_random(120);
      drain();
      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
hw/rtl/rct_pkg.sv
hw/rtl/rct_cmd_queue.sv
hw/rtl/rct_front.sv
hw/rtl/rct_back.sv
hw/rtl/ransac_consensus_tracker_top.sv
sim/tb_ransac_consensus_tracker_top.sv
